/* rtl/bcsd_pkg.sv */
// ----------------------------------------------------------------------------
// bcsd_pkg
// Shared types and constants of the buddy-core stall detector: transaction
// payloads, ring-select result, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bcsd_pkg;

    // fixed field widths
    localparam int CORE_IDX_W = 3;
    localparam int MASK_W     = 8;
    localparam int CLOCK_W    = 64;
    localparam int STAMP_W    = 44;
    localparam int COUNT_W    = 32;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // largest core count that the 3-bit reporter and 8-bit masks can address
    localparam int MAX_CORES  = 8;

    // threshold limits
    localparam logic [THR_W-1:0] MIN_THRESHOLD   = 16'd10;
    localparam logic [THR_W-1:0] RESET_THRESHOLD = 16'd20;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHECKER_ENABLE = 2'd0,
        REG_THRESHOLD_MS   = 2'd1,
        REG_CORE_MASK      = 2'd2
    } t_cfg_reg;

    // input transaction
    typedef struct packed {
        logic [CORE_IDX_W-1:0] reporter_core;
        logic [CLOCK_W-1:0]    clock_ns;
        logic [MASK_W-1:0]     irq_busy_mask;
        logic [MASK_W-1:0]     ipi_done_mask;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic                  stall_found;
        logic [CORE_IDX_W-1:0] victim_core;
        logic                  stall_in_irq;
        logic                  raise_ipi;
        logic                  neighbour_valid;
    } t_out_item;

    // neighbour search result
    typedef struct packed {
        logic                  found;
        logic [CORE_IDX_W-1:0] idx;
    } t_ring_sel;

endpackage

`default_nettype wire

/* rtl/bcsd_ring_sel.sv */
// ----------------------------------------------------------------------------
// bcsd_ring_sel
// Finds the next enabled core after the reporter in ring order, wrapping
// around; the reporter itself never counts as its own neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module bcsd_ring_sel #(
    parameter int N_CORES = 8
) (
    input  wire logic [$clog2(N_CORES)-1:0] i_rep,
    input  wire logic [N_CORES-1:0]         i_mask,
    output bcsd_pkg::t_ring_sel             o_sel
);

    localparam int IDXW = $clog2(N_CORES);
    localparam logic [IDXW:0] N_L = (IDXW+1)'(N_CORES);

    // priority scan over the other cores, nearest first
    always_comb begin
        logic [IDXW:0]   sum;
        logic [IDXW-1:0] cand;
        o_sel = '0;
        for (int k = 1; k < N_CORES; k++) begin
            sum = {1'b0, i_rep} + (IDXW+1)'(k);
            if (sum >= N_L) begin
                sum = sum - N_L;
            end
            cand = sum[IDXW-1:0];
            if (!o_sel.found && i_mask[cand]) begin
                o_sel.found = 1'b1;
                o_sel.idx   = bcsd_pkg::CORE_IDX_W'(cand);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/bcsd_core_state.sv */
// ----------------------------------------------------------------------------
// bcsd_core_state
// Per-core stamps, tick counts, seen counts and pending bits, with the stall
// judgement for the selected neighbour. All updates happen on a fire cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bcsd_core_state #(
    parameter int N_CORES = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_fire,
    input  wire logic                              i_enable,
    input  wire logic [bcsd_pkg::THR_W-1:0]        i_threshold,
    input  wire logic                              i_rep_ok,
    input  wire logic [$clog2(N_CORES)-1:0]        i_rep,
    input  wire logic [bcsd_pkg::STAMP_W-1:0]      i_now,
    input  wire logic [N_CORES-1:0]                i_busy,
    input  wire logic [N_CORES-1:0]                i_done,
    input  wire bcsd_pkg::t_ring_sel               i_sel,
    output bcsd_pkg::t_out_item                    o_result
);

    localparam int IDXW = $clog2(N_CORES);

    logic [bcsd_pkg::STAMP_W-1:0] r_stamp [N_CORES];
    logic [bcsd_pkg::STAMP_W-1:0] n_stamp [N_CORES];
    logic [bcsd_pkg::COUNT_W-1:0] r_tick  [N_CORES];
    logic [bcsd_pkg::COUNT_W-1:0] n_tick  [N_CORES];
    logic [bcsd_pkg::COUNT_W-1:0] r_seen  [N_CORES];
    logic [bcsd_pkg::COUNT_W-1:0] n_seen  [N_CORES];
    logic [N_CORES-1:0]           r_pending;
    logic [N_CORES-1:0]           n_pending;

    logic [IDXW-1:0]              victim;
    logic                         check;
    logic [bcsd_pkg::STAMP_W:0]   diff;
    logic                         late;
    logic                         stalled;
    logic [N_CORES-1:0]           pend_live;

    assign victim = i_sel.idx[IDXW-1:0];
    assign check  = i_enable && i_rep_ok && i_sel.found;

    // pending bits after this transaction's done mask
    assign pend_live = r_pending & ~i_done;

    // elapsed time; no borrow means now >= stamp, threshold >= 10 rules out zero
    assign diff    = {1'b0, i_now} - {1'b0, r_stamp[victim]};
    assign late    = !diff[bcsd_pkg::STAMP_W] &&
                     (diff[bcsd_pkg::STAMP_W-1:0] >= bcsd_pkg::STAMP_W'(i_threshold));
    assign stalled = check && (r_seen[victim] == r_tick[victim]) && late;

    // result of this transaction
    always_comb begin
        o_result                 = '0;
        o_result.neighbour_valid = check;
        o_result.victim_core     = check ? i_sel.idx : '0;
        o_result.stall_found     = stalled;
        o_result.stall_in_irq    = stalled && i_busy[victim];
        o_result.raise_ipi       = stalled && !i_busy[victim] && !pend_live[victim];
    end

    // next state
    always_comb begin
        n_stamp   = r_stamp;
        n_tick    = r_tick;
        n_seen    = r_seen;
        n_pending = r_pending;
        if (i_fire) begin
            n_pending = pend_live;
            if (i_enable && i_rep_ok) begin
                n_stamp[i_rep] = i_now;
                n_tick[i_rep]  = r_tick[i_rep] + 1'b1;
            end
            if (stalled) begin
                n_stamp[victim] = i_now;
                if (o_result.raise_ipi) begin
                    n_pending[victim] = 1'b1;
                end
            end else if (check) begin
                n_seen[victim] = r_tick[victim];
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < N_CORES; c++) begin
                r_stamp[c] <= '0;
                r_tick[c]  <= '0;
                r_seen[c]  <= '0;
            end
            r_pending <= '0;
        end else begin
            r_stamp   <= n_stamp;
            r_tick    <= n_tick;
            r_seen    <= n_seen;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

/* rtl/buddy_core_stall_detector_top.sv */
// ----------------------------------------------------------------------------
// buddy_core_stall_detector_top
// Buddy-core stall detector: each core tick stamps the reporter and checks
// the next enabled core in the ring for a stall.
//
//   channel  signals                               payload
//   input    i_in_valid / o_in_ready               i_in  (t_in_item)
//   output   o_out_valid / i_out_ready             o_out (t_out_item)
//   config   i_cfg_we, i_cfg_index, i_cfg_wdata    write only, no wait
//
// One transaction per cycle while the output is not stalled, through an input
// register, then the stamp/count update and stall judgement into the result
// register. Synchronous active-low reset clears all per-core state, sets
// checking on, threshold 20 and an empty core mask. A stalled output keeps
// its result; one more transaction waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_core_stall_detector_top #(
    parameter int NUM_CORES   = 8,
    parameter int CLOCK_SHIFT = 20
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire bcsd_pkg::t_in_item                i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output bcsd_pkg::t_out_item                    o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [bcsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bcsd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int ACTIVE = (NUM_CORES < bcsd_pkg::MAX_CORES) ? NUM_CORES
                                                              : bcsd_pkg::MAX_CORES;
    localparam int IDXW   = $clog2(ACTIVE);
    localparam logic [bcsd_pkg::CORE_IDX_W:0] ACTIVE_L = (bcsd_pkg::CORE_IDX_W+1)'(ACTIVE);

    // configuration registers
    logic                          r_enable;
    logic [bcsd_pkg::THR_W-1:0]    r_threshold;
    logic [bcsd_pkg::MASK_W-1:0]   r_mask;

    // input register
    logic                          r_in_valid;
    logic [bcsd_pkg::CORE_IDX_W-1:0] r_rep;
    logic [bcsd_pkg::STAMP_W-1:0]  r_now;
    logic [bcsd_pkg::MASK_W-1:0]   r_busy;
    logic [bcsd_pkg::MASK_W-1:0]   r_done;

    // result register
    logic                          r_out_valid;
    bcsd_pkg::t_out_item           r_out;

    logic [bcsd_pkg::CLOCK_W-1:0]  shifted;
    logic                          w_advance;
    logic                          w_in_fire;
    logic                          rep_ok;
    bcsd_pkg::t_ring_sel           sel;
    bcsd_pkg::t_out_item           result;

    // handshake
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // coarse timestamp
    assign shifted = i_in.clock_ns >> CLOCK_SHIFT;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_threshold <= bcsd_pkg::RESET_THRESHOLD;
            r_mask      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bcsd_pkg::REG_CHECKER_ENABLE: r_enable <= i_cfg_wdata[0];
                bcsd_pkg::REG_THRESHOLD_MS: begin
                    r_threshold <= (i_cfg_wdata < bcsd_pkg::MIN_THRESHOLD) ?
                                   bcsd_pkg::MIN_THRESHOLD : i_cfg_wdata;
                end
                bcsd_pkg::REG_CORE_MASK: r_mask <= i_cfg_wdata[bcsd_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_rep  <= i_in.reporter_core;
            r_now  <= shifted[bcsd_pkg::STAMP_W-1:0];
            r_busy <= i_in.irq_busy_mask;
            r_done <= i_in.ipi_done_mask;
        end
    end

    assign rep_ok = {1'b0, r_rep} < ACTIVE_L;

    // neighbour search
    bcsd_ring_sel #(
        .N_CORES (ACTIVE)
    ) u_ring_sel (
        .i_rep  (r_rep[IDXW-1:0]),
        .i_mask (r_mask[ACTIVE-1:0]),
        .o_sel  (sel)
    );

    // per-core state and stall judgement
    bcsd_core_state #(
        .N_CORES (ACTIVE)
    ) u_core_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_advance),
        .i_enable    (r_enable),
        .i_threshold (r_threshold),
        .i_rep_ok    (rep_ok),
        .i_rep       (r_rep[IDXW-1:0]),
        .i_now       (r_now),
        .i_busy      (r_busy[ACTIVE-1:0]),
        .i_done      (r_done[ACTIVE-1:0]),
        .i_sel       (sel),
        .o_result    (result)
    );

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= result;
        end
    end

`ifndef NO_ASSERTIONS
    // a stall is only reported against a checked neighbour
    a_stall_has_neighbour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.stall_found |-> r_out.neighbour_valid)
        else $error("stall reported without a neighbour");

    // interrupt request only for a task-type stall
    a_ipi_task_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.raise_ipi |-> r_out.stall_found && !r_out.stall_in_irq)
        else $error("interrupt request without a task stall");

    // a transaction leaving the input register lands in the result register
    a_advance_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result lost after advance");

    // a held result is not overwritten
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))
        else $error("pending result changed");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the buddy-core stall detector. A directed plan walks
// the empty mask, the lone core, threshold edges, future stamps, pending
// interrupt handling and the disabled checker. Random phases follow, one per
// register setting, with well-formed tick streams and some noise, under
// varying sender and receiver idling. Every result is compared against a
// cycle-free model of the per-core stamp, count and pending state.
// ----------------------------------------------------------------------------

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NCORES        = 8;
    localparam int          CLOCK_SHIFT   = 20;
    localparam logic [63:0] MS            = 64'd1 << CLOCK_SHIFT;
    localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          HOLD_CYCLES   = 64;
    localparam int          NUM_PHASES    = 8;
    localparam int          TICKS_PER_PHASE = 62;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          NUM_PLAN_ROWS = 28;

    localparam int STAMP_W = bcsd_pkg::STAMP_W;
    localparam int COUNT_W = bcsd_pkg::COUNT_W;
    localparam int MASK_W  = bcsd_pkg::MASK_W;
    localparam int THR_W   = bcsd_pkg::THR_W;

    // register indexes
    localparam bcsd_pkg::t_cfg_reg R_EN   = bcsd_pkg::REG_CHECKER_ENABLE;
    localparam bcsd_pkg::t_cfg_reg R_THR  = bcsd_pkg::REG_THRESHOLD_MS;
    localparam bcsd_pkg::t_cfg_reg R_MASK = bcsd_pkg::REG_CORE_MASK;

    localparam bcsd_pkg::t_out_item NO_RESULT   = '0;
    localparam bcsd_pkg::t_out_item FIRST_STALL = '{1'b1, 3'd1, 1'b0, 1'b1, 1'b1};

    typedef enum logic {ROW_TICK, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        bcsd_pkg::t_cfg_reg  sel;
        logic [15:0]         val;
        logic [2:0]          rep;
        logic [63:0]         clk_ns;
        logic [7:0]          busy;
        logic [7:0]          done;
        logic                typed;
        bcsd_pkg::t_out_item want;
    } t_plan_row;

    typedef struct packed {
        logic                given;
        bcsd_pkg::t_out_item value;
    } t_typed_want;

    // directed plan: register writes wait for an idle block
    t_plan_row directed_plan [NUM_PLAN_ROWS] = '{
        // empty mask right after reset, then all-ones extremes
        '{ROW_TICK,  R_EN,   16'd0,    3'd0, 64'd0,    8'h00, 8'h00, 1'b1, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd7, ALL_ONES, 8'hFF, 8'hFF, 1'b1, NO_RESULT},
        // lone enabled core has no neighbour, other reporters check it
        '{ROW_WRITE, R_MASK, 16'h01,   3'd0, 64'd0,    8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd0, 5*MS,     8'h00, 8'h00, 1'b1, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd3, 6*MS,     8'h00, 8'h00, 1'b0, NO_RESULT},
        // threshold below minimum saturates
        '{ROW_WRITE, R_THR,  16'd0,    3'd0, 64'd0,    8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_WRITE, R_MASK, 16'hFF,   3'd0, 64'd0,    8'h00, 8'h00, 1'b0, NO_RESULT},
        // silent core 1: task stall, then pending, done clears, irq stall
        '{ROW_TICK,  R_EN,   16'd0,    3'd0, 100*MS,   8'h00, 8'h00, 1'b1, FIRST_STALL},
        '{ROW_TICK,  R_EN,   16'd0,    3'd0, 200*MS,   8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd0, 300*MS,   8'h00, 8'h02, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd0, 400*MS,   8'h02, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd1, 400*MS,   8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd0, 405*MS,   8'h00, 8'h00, 1'b0, NO_RESULT},
        // threshold boundary on core 4: moved count, exact threshold, one short
        '{ROW_TICK,  R_EN,   16'd0,    3'd4, 500*MS,   8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd3, 509*MS,   8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd3, 510*MS,   8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd3, 519*MS,   8'h00, 8'h00, 1'b0, NO_RESULT},
        // max clock, then wrap to core 0 whose stamp lies in the future
        '{ROW_TICK,  R_EN,   16'd0,    3'd0, ALL_ONES, 8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd7, 64'd0,    8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd7, 1*MS,     8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_WRITE, R_THR,  16'hFFFF, 3'd0, 64'd0,    8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd2, 600*MS,   8'h00, 8'h00, 1'b0, NO_RESULT},
        // disabled checker still clears pending bits
        '{ROW_WRITE, R_EN,   16'd0,    3'd0, 64'd0,    8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd5, 700*MS,   8'hFF, 8'hFF, 1'b1, NO_RESULT},
        '{ROW_WRITE, R_EN,   16'd1,    3'd0, 64'd0,    8'h00, 8'h00, 1'b0, NO_RESULT},
        // only the top core enabled
        '{ROW_WRITE, R_MASK, 16'h80,   3'd0, 64'd0,    8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd7, 800*MS,   8'h00, 8'h00, 1'b1, NO_RESULT},
        '{ROW_TICK,  R_EN,   16'd0,    3'd6, 800*MS,   8'h00, 8'h00, 1'b0, NO_RESULT}
    };

    // dut connections
    logic                i_clk     = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    bcsd_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b1;
    bcsd_pkg::t_out_item out_item;
    logic                cfg_we    = 1'b0;
    bcsd_pkg::t_cfg_reg  cfg_idx   = R_EN;
    logic [15:0]         cfg_wdata = '0;

    // model copy of registers and per-core state
    logic                chk_enable = 1'b1;
    logic [THR_W-1:0]    cfg_thr    = bcsd_pkg::RESET_THRESHOLD;
    logic [MASK_W-1:0]   cfg_mask   = '0;
    logic [STAMP_W-1:0]  core_stamp      [NCORES] = '{default: '0};
    logic [COUNT_W-1:0]  core_ticks      [NCORES] = '{default: '0};
    logic [COUNT_W-1:0]  core_seen       [NCORES] = '{default: '0};
    logic                ipi_outstanding [NCORES] = '{default: 1'b0};

    bcsd_pkg::t_out_item pending_results [$];
    t_typed_want         typed_wants     [$];

    // idling controls and long receiver hold-off
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_asks   = 0;
    int          hold_served = 0;
    int          hold_left   = 0;

    // run statistics
    int          mismatches    = 0;
    int          ticks_sent    = 0;
    int          results_seen  = 0;
    int          stalls_seen   = 0;
    int          irq_stalls    = 0;
    int          ipi_requests  = 0;
    int          settings_used = 0;
    int          cycles        = 0;
    logic [43:0] sim_ms        = '0;

    buddy_core_stall_detector_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // judge one tick: stamp the reporter, check its ring neighbour
    function automatic bcsd_pkg::t_out_item judge_tick(input bcsd_pkg::t_in_item it);
        bcsd_pkg::t_out_item r;
        logic [STAMP_W-1:0]  now_ms;
        logic [2:0]          rep;
        int                  victim;
        bit                  found;
        r      = '0;
        rep    = it.reporter_core;
        now_ms = it.clock_ns[CLOCK_SHIFT +: STAMP_W];
        victim = 0;
        found  = 1'b0;
        for (int c = 0; c < NCORES; c++) begin
            if (it.ipi_done_mask[c]) ipi_outstanding[c] = 1'b0;
        end
        if (!chk_enable) return r;
        core_stamp[rep] = now_ms;
        core_ticks[rep] = core_ticks[rep] + 1;
        // next enabled core after the reporter, wrapping, never itself
        for (int k = 1; k < NCORES; k++) begin
            if (!found && cfg_mask[(rep + k) % NCORES]) begin
                found  = 1'b1;
                victim = (rep + k) % NCORES;
            end
        end
        if (!found) return r;
        r.victim_core     = 3'(victim);
        r.neighbour_valid = 1'b1;
        if (core_seen[victim] == core_ticks[victim] && now_ms > core_stamp[victim] &&
            now_ms - core_stamp[victim] >= STAMP_W'(cfg_thr)) begin
            core_stamp[victim] = now_ms;
            r.stall_found = 1'b1;
            if (it.irq_busy_mask[victim]) begin
                r.stall_in_irq = 1'b1;
            end else if (!ipi_outstanding[victim]) begin
                ipi_outstanding[victim] = 1'b1;
                r.raise_ipi = 1'b1;
            end
        end else begin
            core_seen[victim] = core_ticks[victim];
        end
        return r;
    endfunction

    // model register write
    function automatic void apply_reg(input bcsd_pkg::t_cfg_reg sel, input logic [15:0] val);
        case (sel)
            R_EN:    chk_enable = val[0];
            R_THR:   cfg_thr = (val < bcsd_pkg::MIN_THRESHOLD) ? bcsd_pkg::MIN_THRESHOLD
                                                               : val;
            R_MASK:  cfg_mask = val[MASK_W-1:0];
            default: ;
        endcase
    endfunction

    // field-by-field compare against the oldest expectation
    function automatic void check_result(input bcsd_pkg::t_out_item want,
                                         input bcsd_pkg::t_out_item got);
        bit bad;
        bad = (got.stall_found !== want.stall_found) ||
              (got.victim_core !== want.victim_core) ||
              (got.stall_in_irq !== want.stall_in_irq) || (got.raise_ipi !== want.raise_ipi) ||
              (got.neighbour_valid !== want.neighbour_valid);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: want found=%0b victim=%0d irq=%0b ipi=%0b nv=%0b,",
                          " got found=%0b victim=%0d irq=%0b ipi=%0b nv=%0b"},
                         want.stall_found, want.victim_core, want.stall_in_irq, want.raise_ipi,
                         want.neighbour_valid, got.stall_found, got.victim_core,
                         got.stall_in_irq, got.raise_ipi, got.neighbour_valid);
        end
    endfunction

    // monitor: results, accepted ticks, register writes
    always @(posedge i_clk) begin : monitor
        t_typed_want         tw;
        bcsd_pkg::t_out_item predicted;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (out_item.stall_found) stalls_seen++;
                if (out_item.stall_in_irq) irq_stalls++;
                if (out_item.raise_ipi) ipi_requests++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result with nothing expected");
                end else begin
                    check_result(pending_results.pop_front(), out_item);
                end
            end
            if (in_valid && in_ready) begin
                ticks_sent++;
                tw = (typed_wants.size() != 0) ? typed_wants.pop_front() : '0;
                predicted = judge_tick(in_item);
                pending_results.push_back(tw.given ? tw.value : predicted);
            end
            if (cfg_we) apply_reg(cfg_idx, cfg_wdata);
        end
    end

    // receiver: random stalls plus a counted long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_served != hold_asks) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // offer one tick transaction, leave valid high at acceptance
    task automatic send_tick(input bcsd_pkg::t_in_item it, input bit typed,
                             input bcsd_pkg::t_out_item want);
        t_typed_want tw;
        tw.given = typed;
        tw.value = want;
        typed_wants.push_back(tw);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // drop valid and wait until every result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input bcsd_pkg::t_cfg_reg sel, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= sel;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly enabled reporters on an advancing clock, some noise
    task automatic make_random_tick(output bcsd_pkg::t_in_item it);
        int roll;
        roll = $urandom_range(0, 99);
        it.irq_busy_mask = 8'($urandom);
        it.ipi_done_mask = 8'($urandom & $urandom);
        if (roll < 10) begin
            it.reporter_core = 3'($urandom);
            it.clock_ns      = {$urandom, $urandom};
        end else begin
            if (roll < 15) sim_ms = sim_ms + 44'($urandom_range(0, 70000));
            else           sim_ms = sim_ms + 44'($urandom_range(0, 15));
            it.reporter_core = 3'($urandom);
            if (cfg_mask != 0)
                while (!cfg_mask[it.reporter_core]) it.reporter_core = 3'($urandom);
            it.clock_ns = {sim_ms, 20'($urandom)};
        end
    endtask

    initial begin : stimulus
        bcsd_pkg::t_in_item it;
        logic [15:0]        thr_val;
        logic [15:0]        mask_val;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan
        for (int r = 0; r < NUM_PLAN_ROWS; r++) begin
            if (directed_plan[r].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(directed_plan[r].sel, directed_plan[r].val);
                settings_used++;
            end else begin
                it.reporter_core = directed_plan[r].rep;
                it.clock_ns      = directed_plan[r].clk_ns;
                it.irq_busy_mask = directed_plan[r].busy;
                it.ipi_done_mask = directed_plan[r].done;
                send_tick(it, directed_plan[r].typed, directed_plan[r].want);
            end
        end
        sim_ms = 44'd1000;

        // random phases, one register setting and one idling style each
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
                default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
            endcase
            case (p)
                0: begin thr_val = 16'd10;    mask_val = 16'hFF; end
                1: begin thr_val = 16'd3;     mask_val = 16'($urandom_range(1, 255)); end
                2: begin thr_val = 16'hFFFF;  mask_val = 16'h81; end
                3: begin thr_val = 16'd20;    mask_val = 16'h00; end
                4: begin thr_val = 16'($urandom_range(10, 60)); mask_val = 16'hFF; end
                5: begin thr_val = 16'($urandom); mask_val = 16'($urandom_range(1, 255)); end
                6: begin thr_val = 16'd15;    mask_val = 16'h01; end
                default: begin thr_val = 16'd12; mask_val = 16'($urandom_range(1, 255)); end
            endcase
            write_reg(R_EN, (p == 6) ? 16'd0 : 16'd1);
            write_reg(R_THR, thr_val);
            write_reg(R_MASK, mask_val);
            settings_used++;
            if (p % 4 == 0) hold_asks++;
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                make_random_tick(it);
                send_tick(it, 1'b0, NO_RESULT);
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end
        $display("covered %0d ticks and %0d results over %0d register settings",
                 ticks_sent, results_seen, settings_used);
        $display("saw %0d stalls (%0d irq-type), %0d stack-sample requests, %0d mismatches",
                 stalls_seen, irq_stalls, ipi_requests, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
